// ===== rtl/rctt_pkg.sv =====
package rctt_pkg;

  localparam int RCTT_TABLE_ENTRIES   = 16;
  localparam int RCTT_SLOTS_PER_ENTRY = 4;

  localparam int ADDR_W = 48;
  localparam int CYC_W  = 48;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHECK  = 2'd1,
    OP_EXPIRE = 2'd2,
    OP_NOP    = 2'd3
  } rctt_op_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic [CYC_W-1:0]  cycle_value;
  } rctt_in_t;

  typedef struct packed {
    logic       full_res;
    logic       accepted;
    logic [4:0] entries_used;
    logic [2:0] slots_used;
    logic [4:0] peak_entries;
    logic [2:0] peak_slots;
  } rctt_out_t;

  // Token that walks the cell chain.
  typedef struct packed {
    logic vld;    // token present at this cell
    logic exec;   // 0: lookup pass, 1: execute pass
    logic hit;    // address found (lookup result, carried into execute)
    logic alloc;  // an entry was allocated upstream
    logic acc;    // insert accepted
    logic full;   // check found the addressed entry full
  } rctt_tok_t;

endpackage

// ===== rtl/return_cycle_tracking_table_unit.sv =====
// Channel   Signals          Direction  Handshake
// -------   --------------   ---------  --------------------------------------
// command   start, cmd       in         word taken at clk edge with start & !busy
// busy      busy             out        high while a command is in flight
// result    done, rsp        out        word valid for the one cycle done is high
//
// For each command a token walks the cell chain twice, one cell per cycle,
// first to look the address up, then to execute. busy drops in the done cycle,
// so the next command can be taken while the result is shown.
// Reset (rst, synchronous) empties the table and clears the peak counters.
// The result side cannot stall; rsp is simply overwritten by the next command.
module return_cycle_tracking_table_unit import rctt_pkg::*; #(
  parameter int TABLE_ENTRIES   = RCTT_TABLE_ENTRIES,
  parameter int SLOTS_PER_ENTRY = RCTT_SLOTS_PER_ENTRY
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  rctt_in_t  cmd,
  output logic      busy,
  output logic      done,
  output rctt_out_t rsp
);

  localparam int N  = TABLE_ENTRIES;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $clog2(SLOTS_PER_ENTRY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EXEC = 3'b100
  } state_t;

  state_t          state, state_next;
  rctt_in_t        cmd_q, cmd_q_next;
  rctt_tok_t       head, head_next;
  rctt_out_t       rsp_next;
  logic            done_next;
  logic [CW-1:0]   peak_e, peak_e_next;
  logic [SW-1:0]   peak_s, peak_s_next;
  logic            full_v, acc_v;

  // Token chain: index 0 is driven here, index N comes back from the last cell.
  rctt_tok_t       tok [N+1];
  logic [CW-1:0]   cnt [N+1];
  logic [SW-1:0]   ns  [N+1];

  assign tok[0] = head;
  assign cnt[0] = '0;
  assign ns[0]  = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    rctt_cell #(
      .TABLE_ENTRIES  (TABLE_ENTRIES),
      .SLOTS_PER_ENTRY(SLOTS_PER_ENTRY)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd_q),
      .tok_in (tok[i]),
      .cnt_in (cnt[i]),
      .ns_in  (ns[i]),
      .tok_out(tok[i+1]),
      .cnt_out(cnt[i+1]),
      .ns_out (ns[i+1])
    );
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd_q_next  = cmd_q;
    head_next   = '0;
    rsp_next    = rsp;
    done_next   = 1'b0;
    peak_e_next = peak_e;
    peak_s_next = peak_s;
    full_v      = 1'b0;
    acc_v       = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q_next    = cmd;
          head_next.vld = 1'b1;   // lookup pass
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok[N].vld) begin
          head_next.vld  = 1'b1;  // execute pass, knowing whether the address hit
          head_next.exec = 1'b1;
          head_next.hit  = tok[N].hit;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (tok[N].vld) begin
          case (rctt_op_t'(cmd_q.opcode))
            OP_INSERT: begin
              acc_v = tok[N].acc;
              // peaks are updated on every insert, dropped or not
              if (cnt[N] > peak_e) peak_e_next = cnt[N];
              if (ns[N] > peak_s)  peak_s_next = ns[N];
            end
            OP_CHECK: begin
              // absent address: full means no entry left to allocate
              full_v = tok[N].hit ? tok[N].full : (cnt[N] == CW'(N));
            end
            default: ;
          endcase
          rsp_next.full_res     = full_v;
          rsp_next.accepted     = acc_v;
          rsp_next.entries_used = 5'(cnt[N]);
          rsp_next.slots_used   = 3'(ns[N]);
          rsp_next.peak_entries = 5'(peak_e_next);
          rsp_next.peak_slots   = 3'(peak_s_next);
          done_next             = 1'b1;
          state_next            = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      done   <= 1'b0;
      peak_e <= '0;
      peak_s <= '0;
    end else begin
      state  <= state_next;
      head   <= head_next;
      done   <= done_next;
      peak_e <= peak_e_next;
      peak_s <= peak_s_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q <= cmd_q_next;
    rsp   <= rsp_next;
  end

endmodule

// ===== rtl/rctt_cell.sv =====
module rctt_cell import rctt_pkg::*; #(
  parameter int TABLE_ENTRIES   = RCTT_TABLE_ENTRIES,
  parameter int SLOTS_PER_ENTRY = RCTT_SLOTS_PER_ENTRY,
  localparam int CW = $clog2(TABLE_ENTRIES + 1),
  localparam int SW = $clog2(SLOTS_PER_ENTRY + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  rctt_in_t        cmd,
  input  rctt_tok_t       tok_in,
  input  logic [CW-1:0]   cnt_in,
  input  logic [SW-1:0]   ns_in,
  output rctt_tok_t       tok_out,
  output logic [CW-1:0]   cnt_out,
  output logic [SW-1:0]   ns_out
);

  localparam int S = SLOTS_PER_ENTRY;

  logic                valid, valid_next;
  logic [ADDR_W-1:0]   address, address_next;
  logic [S-1:0]        slot_valid, slot_valid_next;
  logic [CYC_W-1:0]    slot_cycle [S];
  logic [CYC_W-1:0]    slot_cycle_next [S];

  rctt_tok_t           tok_next;
  logic [CW-1:0]       cnt_next;
  logic [SW-1:0]       ns_next;
  logic [SW-1:0]       pop;
  logic                match, match_after, alloc_here;
  logic [S-1:0]        eq, le, free, pick;

  always_comb begin
    valid_next      = valid;
    address_next    = address;
    slot_valid_next = slot_valid;
    slot_cycle_next = slot_cycle;
    tok_next        = tok_in;
    alloc_here      = 1'b0;
    match           = valid && (address == cmd.address);
    for (int s = 0; s < S; s++) begin
      eq[s] = slot_valid[s] && (slot_cycle[s] == cmd.cycle_value);
      le[s] = slot_valid[s] && (slot_cycle[s] <= cmd.cycle_value);
    end
    free = ~slot_valid;
    pick = free & (~free + S'(1));

    if (!tok_in.exec) begin
      tok_next.hit = tok_in.hit | match;
    end else begin
      case (rctt_op_t'(cmd.opcode))
        OP_INSERT: begin
          if (tok_in.hit) begin
            if (match) begin
              if (|eq) begin
                tok_next.acc = 1'b1;
              end else if (|free) begin
                slot_valid_next = slot_valid | pick;
                for (int s = 0; s < S; s++) begin
                  if (pick[s]) slot_cycle_next[s] = cmd.cycle_value;
                end
                tok_next.acc = 1'b1;
              end
            end
          end else if (!valid && !tok_in.alloc) begin
            // lowest free entry takes the new address
            valid_next         = 1'b1;
            address_next       = cmd.address;
            slot_valid_next    = S'(1);
            slot_cycle_next[0] = cmd.cycle_value;
            tok_next.alloc     = 1'b1;
            tok_next.acc       = 1'b1;
            alloc_here         = 1'b1;
          end
        end
        OP_CHECK: begin
          if (match) tok_next.full = &slot_valid;
        end
        OP_EXPIRE: begin
          if (valid) begin
            slot_valid_next = slot_valid & ~le;
            if (slot_valid_next == '0) valid_next = 1'b0;
          end
        end
        default: ;
      endcase
    end

    pop = '0;
    for (int s = 0; s < S; s++) begin
      pop = pop + SW'(slot_valid_next[s]);
    end
    match_after = valid_next && (match || alloc_here);
    ns_next     = match_after ? pop : ns_in;
    cnt_next    = cnt_in + CW'(valid_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      slot_valid <= '0;
      tok_out    <= '0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.vld && tok_in.exec) begin
        valid      <= valid_next;
        slot_valid <= slot_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_out <= cnt_next;
    ns_out  <= ns_next;
    if (tok_in.vld && tok_in.exec) begin
      address    <= address_next;
      slot_cycle <= slot_cycle_next;
    end
  end

endmodule
